// File: rtl/core/hrsba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap region select and bump allocator: shared package
// Request and status codes, the request and result records, and the constants
// and helper function that the datapath and the top level both use.
// ----------------------------------------------------------------------------
package hrsba_pkg;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_BEGIN  = 2'd0,
        REQ_ENTRY  = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_ALLOC  = 2'd3
    } req_type_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ZERO   = 2'd1,
        ST_OOM    = 2'd2,
        ST_NOHEAP = 2'd3
    } status_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KERNEL_END    = 2'd0;
    localparam logic [1:0] CFG_RAMDISK_START = 2'd1;
    localparam logic [1:0] CFG_RAMDISK_BYTES = 2'd2;

    localparam logic [31:0] LOW_MEM_FLOOR = 32'h0010_0000;
    localparam logic [31:0] KIND_USABLE   = 32'd1;
    localparam logic [31:0] ALIGN_ADD     = 32'd15;
    localparam logic [31:0] ALIGN_MASK    = 32'hFFFF_FFF0;

    // One incoming request.
    typedef struct packed {
        req_type_t   req_type;
        logic [31:0] region_addr_lo;
        logic [31:0] region_addr_hi;
        logic [31:0] region_len_lo;
        logic [31:0] region_len_hi;
        logic [31:0] region_kind;
        logic [31:0] request_bytes;
    } item_t;

    // One result.
    typedef struct packed {
        status_t     status;
        logic [31:0] block_addr;
    } result_t;

    // Round up to a multiple of 16, wrapping modulo 2^32.
    function automatic logic [31:0] round16(input logic [31:0] v);
        return (v + ALIGN_ADD) & ALIGN_MASK;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/hrsba_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap region select and bump allocator: execution stage
// Holds the heap window, bump pointer and best-region tracker, and works out
// the result of one request per cycle, while step is high, from the registered request.
// ----------------------------------------------------------------------------
module hrsba_exec (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire hrsba_pkg::item_t  item,
    input  wire logic [31:0]       want,
    output hrsba_pkg::result_t     result
);

    logic [31:0] base_reg,      base_next;
    logic [31:0] limit_reg,     limit_next;
    logic [31:0] next_free_reg, next_free_next;
    logic [31:0] best_lo_reg,   best_lo_next;
    logic [31:0] best_hi_reg,   best_hi_next;
    logic [31:0] best_len_reg,  best_len_next;
    logic        fixed_reg,     fixed_next;

    logic [31:0] entry_end;
    logic        entry_usable;
    logic        entry_contains;
    logic        adopt;
    logic [31:0] base_eff;
    logic [31:0] limit_eff;
    logic [32:0] rounded;
    logic [33:0] bump_sum;

    // Shared arithmetic for the request held in the input register.
    assign entry_end      = item.region_addr_lo + item.region_len_lo;
    assign entry_usable   = !fixed_reg && (item.region_kind == hrsba_pkg::KIND_USABLE)
                            && (item.region_addr_hi == 32'd0)
                            && (item.region_len_hi == 32'd0);
    assign entry_contains = (item.region_addr_lo <= want) && (want < entry_end);
    assign adopt          = !fixed_reg && (best_lo_reg != 32'd0)
                            && (best_hi_reg > best_lo_reg);
    assign base_eff       = adopt ? hrsba_pkg::round16(best_lo_reg) : base_reg;
    assign limit_eff      = adopt ? best_hi_reg : limit_reg;
    assign rounded        = ({1'b0, item.request_bytes} + 33'd15) & ~33'h0_0000_000F;
    assign bump_sum       = {2'b00, next_free_reg} + {1'b0, rounded};

    // Next state and result for the current request.
    always_comb
    begin
        base_next         = base_reg;
        limit_next        = limit_reg;
        next_free_next    = next_free_reg;
        best_lo_next      = best_lo_reg;
        best_hi_next      = best_hi_reg;
        best_len_next     = best_len_reg;
        fixed_next        = fixed_reg;
        result.status     = hrsba_pkg::ST_OK;
        result.block_addr = 32'd0;
        case (item.req_type)
            hrsba_pkg::REQ_BEGIN:
            begin
                base_next      = 32'd0;
                limit_next     = 32'd0;
                next_free_next = 32'd0;
                best_lo_next   = 32'd0;
                best_hi_next   = 32'd0;
                best_len_next  = 32'd0;
                fixed_next     = 1'b0;
            end
            hrsba_pkg::REQ_ENTRY:
            begin
                if (entry_usable)
                begin
                    if (entry_contains)
                    begin
                        base_next      = want;
                        limit_next     = entry_end;
                        next_free_next = want;
                        fixed_next     = 1'b1;
                    end
                    else if ((item.region_addr_lo >= hrsba_pkg::LOW_MEM_FLOOR)
                             && (item.region_len_lo > best_len_reg))
                    begin
                        // The wrapped length of an entry is its low length word.
                        best_lo_next  = item.region_addr_lo;
                        best_hi_next  = entry_end;
                        best_len_next = item.region_len_lo;
                    end
                end
            end
            hrsba_pkg::REQ_FINISH:
            begin
                if (adopt)
                begin
                    base_next      = base_eff;
                    limit_next     = limit_eff;
                    next_free_next = base_eff;
                end
                if ((base_eff == 32'd0) || (limit_eff <= base_eff))
                begin
                    result.status = hrsba_pkg::ST_NOHEAP;
                end
            end
            hrsba_pkg::REQ_ALLOC:
            begin
                if (item.request_bytes == 32'd0)
                begin
                    result.status = hrsba_pkg::ST_ZERO;
                end
                else if ((next_free_reg == 32'd0) || (bump_sum > {2'b00, limit_reg}))
                begin
                    result.status = hrsba_pkg::ST_OOM;
                end
                else
                begin
                    result.block_addr = next_free_reg;
                    next_free_next    = bump_sum[31:0];
                end
            end
            default:
            begin
                result.status = hrsba_pkg::ST_OK;
            end
        endcase
    end

    // State registers, updated once per executed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= 32'd0;
            limit_reg     <= 32'd0;
            next_free_reg <= 32'd0;
            best_lo_reg   <= 32'd0;
            best_hi_reg   <= 32'd0;
            best_len_reg  <= 32'd0;
            fixed_reg     <= 1'b0;
        end
        else if (step)
        begin
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            next_free_reg <= next_free_next;
            best_lo_reg   <= best_lo_next;
            best_hi_reg   <= best_hi_next;
            best_len_reg  <= best_len_next;
            fixed_reg     <= fixed_next;
        end
    end

`ifndef SYNTHESIS
    // The bump pointer never falls below the heap base.
    a_next_above_base: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg >= base_reg)
        else $error("bump pointer below heap base");

    // A successful allocation returns an aligned, non-null block.
    a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.req_type == hrsba_pkg::REQ_ALLOC)
         && (result.status == hrsba_pkg::ST_OK))
        |-> ((result.block_addr != 32'd0) && (result.block_addr[3:0] == 4'd0)))
        else $error("allocated block not aligned or null");

    // A successful allocation advances the bump pointer.
    a_alloc_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.req_type == hrsba_pkg::REQ_ALLOC)
         && (result.status == hrsba_pkg::ST_OK))
        |=> (next_free_reg > $past(next_free_reg)))
        else $error("bump pointer did not advance");

    // A begin request leaves the heap empty and unfixed.
    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.req_type == hrsba_pkg::REQ_BEGIN))
        |=> (!fixed_reg && (next_free_reg == 32'd0) && (best_len_reg == 32'd0)))
        else $error("begin request did not clear state");
`endif

endmodule
`default_nettype wire

// File: rtl/core/heap_region_select_bump_alloc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap region select and bump allocator: top level
// Picks the heap window from a streamed memory map and serves bump-pointer
// allocations. An input register feeds the execution stage, which writes a
// result register.
// ----------------------------------------------------------------------------
// A request accepted into the input register is executed from there, and its
// result is written to the result register and offered from it.
// Throughput: one request per cycle while out_stall is low; the execution
// stage works out the result and next allocator state combinationally.
// Reset clears the configuration, the heap state and the pipeline valid flags.
module heap_region_select_bump_alloc (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [31:0] region_addr_lo,
    input  wire logic [31:0] region_addr_hi,
    input  wire logic [31:0] region_len_lo,
    input  wire logic [31:0] region_len_hi,
    input  wire logic [31:0] region_kind,
    input  wire logic [31:0] request_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      block_addr
);

    logic [31:0] kernel_end_reg,    kernel_end_next;
    logic [31:0] ramdisk_start_reg, ramdisk_start_next;
    logic [31:0] ramdisk_bytes_reg, ramdisk_bytes_next;
    logic [31:0] want_reg,          want_next;
    logic [31:0] rd_end;
    logic [31:0] top_used;

    logic                 s1_valid_reg, s1_valid_next;
    hrsba_pkg::item_t     s1_item_reg;
    logic                 out_valid_reg, out_valid_next;
    hrsba_pkg::result_t   out_result_reg;
    hrsba_pkg::result_t   exec_result;
    logic                 advance;
    logic                 accept;
    logic                 step;

    // Configuration writes.
    always_comb
    begin
        kernel_end_next    = kernel_end_reg;
        ramdisk_start_next = ramdisk_start_reg;
        ramdisk_bytes_next = ramdisk_bytes_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                hrsba_pkg::CFG_KERNEL_END:    kernel_end_next    = cfg_data;
                hrsba_pkg::CFG_RAMDISK_START: ramdisk_start_next = cfg_data;
                hrsba_pkg::CFG_RAMDISK_BYTES: ramdisk_bytes_next = cfg_data;
                default:                      kernel_end_next    = kernel_end_reg;
            endcase
        end
    end

    // Desired heap start, registered alongside the configuration itself.
    assign rd_end    = ramdisk_start_next + ramdisk_bytes_next;
    assign top_used  = (kernel_end_next > rd_end) ? kernel_end_next : rd_end;
    assign want_next = hrsba_pkg::round16((top_used > hrsba_pkg::LOW_MEM_FLOOR)
                                          ? top_used : hrsba_pkg::LOW_MEM_FLOOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_end_reg    <= 32'd0;
            ramdisk_start_reg <= 32'd0;
            ramdisk_bytes_reg <= 32'd0;
            want_reg          <= hrsba_pkg::LOW_MEM_FLOOR;
        end
        else
        begin
            kernel_end_reg    <= kernel_end_next;
            ramdisk_start_reg <= ramdisk_start_next;
            ramdisk_bytes_reg <= ramdisk_bytes_next;
            want_reg          <= want_next;
        end
    end

    // Pipeline flow: the stage moves whenever the result register is free
    // or is being emptied.
    assign advance        = !out_valid_reg || !out_stall;
    assign in_stall       = s1_valid_reg && !advance;
    assign accept         = in_valid && !in_stall;
    assign step           = s1_valid_reg && advance;
    assign s1_valid_next  = accept ? 1'b1 : (step ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? step : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input request register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.req_type       <= hrsba_pkg::req_type_t'(req_type);
            s1_item_reg.region_addr_lo <= region_addr_lo;
            s1_item_reg.region_addr_hi <= region_addr_hi;
            s1_item_reg.region_len_lo  <= region_len_lo;
            s1_item_reg.region_len_hi  <= region_len_hi;
            s1_item_reg.region_kind    <= region_kind;
            s1_item_reg.request_bytes  <= request_bytes;
        end
    end

    // Allocator state and per-request datapath.
    hrsba_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (s1_item_reg),
        .want   (want_reg),
        .result (exec_result)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_result_reg <= exec_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_result_reg.status;
    assign block_addr = out_result_reg.block_addr;

endmodule
`default_nettype wire
